/* hw/rtl/mps_pkg.sv */
// Package for the module poll sequencer: sizes, operation codes, register
// indexes and the result record shared by the step logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mps_pkg;

  // Number of polled modules and the widths that follow from it
  localparam int unsigned MODULE_COUNT = 8;
  localparam int unsigned ID_W         = 3;   // bits of a module index
  localparam int unsigned ACTIVE_W     = 4;   // index plus the "passed all" value
  localparam int unsigned TARGET_W     = 3;
  localparam int unsigned REPLY_W      = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned WAIT_W       = 16;
  localparam int unsigned ADDR_W       = 3;

  // Operation codes carried by an item
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLY = 2'd2;

  // Register indexes (taken from paddr bit 2)
  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_RETRY = 1'b1;

  // Reset values of the configuration registers
  localparam logic [ID_W-1:0]   FIRST_RESET = 3'd0;
  localparam logic [WAIT_W-1:0] RETRY_RESET = 16'd10;

  // One result item
  typedef struct packed {
    logic                send_query;
    logic [TARGET_W-1:0] query_target;
    logic [ACTIVE_W-1:0] current_module;
    logic                all_done;
  } mps_result_t;

endpackage

/* hw/rtl/module_poll_sequencer.sv */
// Top level of the module poll sequencer: input register, step logic,
// result register and configuration port. Depends on mps_pkg, mps_apb_regs,
// mps_step.
//
//   port group     direction   handshake            payload
//   item in        in          in_valid_i/in_ready_o   op_i, reply_module_i
//   result out     out         out_valid_o/out_ready_i send_query_o, query_target_o,
//                                                      current_module_o, all_done_o
//   config         in/out      psel/penable/pready     paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; each item is
// held in the input register and its result then comes from the result register.
// The poll state is updated as the item moves into the result register.
// A stalled result holds the result register; the input register then holds
// one more item and ready drops until the output is taken.
// Reset (rst_ni low) clears both registers' valid bits, all flags and the
// wait count, and sets the active module to the first-module reset value.
`timescale 1ns / 1ps

module module_poll_sequencer
  import mps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // item in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [REPLY_W-1:0]  reply_module_i,
  // result out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                send_query_o,
  output logic [TARGET_W-1:0] query_target_o,
  output logic [ACTIVE_W-1:0] current_module_o,
  output logic                all_done_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic               in_vld_q, in_vld_d;
  logic [OP_W-1:0]    op_q;
  logic [REPLY_W-1:0] reply_q;
  logic               out_vld_q, out_vld_d;
  mps_result_t        res_q;
  mps_result_t        res_next;
  logic               advance;
  logic               take_in;
  logic [ID_W-1:0]    first_module;
  logic [WAIT_W-1:0]  retry_limit;

  mps_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .first_module_o (first_module),
    .retry_limit_o  (retry_limit)
  );

  mps_step u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .op_i           (op_q),
    .reply_module_i (reply_q),
    .first_module_i (first_module),
    .retry_limit_i  (retry_limit),
    .result_o       (res_next)
  );

  // Handshake: item moves on when the result register is free or draining
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign take_in    = in_valid_i & in_ready_o;

  assign in_vld_d  = take_in | (in_vld_q & ~advance);
  assign out_vld_d = advance | (out_vld_q & ~out_ready_i);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q    <= op_i;
      reply_q <= reply_module_i;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign send_query_o     = res_q.send_query;
  assign query_target_o   = res_q.query_target;
  assign current_module_o = res_q.current_module;
  assign all_done_o       = res_q.all_done;

endmodule

/* hw/rtl/mps_apb_regs.sv */
// APB-style configuration registers: first module and retry limit.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_apb_regs
  import mps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [ID_W-1:0]   first_module_o,
  output logic [WAIT_W-1:0] retry_limit_o
);

  logic              wr_en;
  logic [ID_W-1:0]   first_q, first_d;
  logic [WAIT_W-1:0] retry_q, retry_d;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    first_d = first_q;
    retry_d = retry_q;
    if (wr_en) begin
      case (paddr[2])
        REG_FIRST: first_d = pwdata[ID_W-1:0];
        REG_RETRY: retry_d = pwdata[WAIT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= FIRST_RESET;
      retry_q <= RETRY_RESET;
    end else begin
      first_q <= first_d;
      retry_q <= retry_d;
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_FIRST: prdata = {{(32-ID_W){1'b0}}, first_q};
      REG_RETRY: prdata = {{(32-WAIT_W){1'b0}}, retry_q};
      default:   prdata = '0;
    endcase
  end

  assign first_module_o = first_q;
  assign retry_limit_o  = retry_q;

endmodule

/* hw/rtl/mps_step.sv */
// Poll state (flags, wait count, active module) and the per-item update.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_step
  import mps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [REPLY_W-1:0] reply_module_i,
  input  logic [ID_W-1:0]    first_module_i,
  input  logic [WAIT_W-1:0]  retry_limit_i,
  output mps_result_t        result_o
);

  logic [MODULE_COUNT-1:0] queried_q, queried_d;
  logic [MODULE_COUNT-1:0] answered_q, answered_d;
  logic [WAIT_W-1:0]       wait_q, wait_d;
  logic [ACTIVE_W-1:0]     active_q, active_d;

  logic              in_range;
  logic [ID_W-1:0]   idx;
  logic [WAIT_W:0]   wait_inc;
  logic              send;
  logic              done;

  assign in_range = (active_q < ACTIVE_W'(MODULE_COUNT));
  assign idx      = active_q[ID_W-1:0];
  assign wait_inc = {1'b0, wait_q} + {{WAIT_W{1'b0}}, 1'b1};

  // Next state for one item
  always_comb begin
    queried_d  = queried_q;
    answered_d = answered_q;
    wait_d     = wait_q;
    active_d   = active_q;
    send       = 1'b0;
    case (op_i)
      OP_CLEAR: begin
        queried_d  = '0;
        answered_d = '0;
        wait_d     = '0;
        active_d   = {{(ACTIVE_W-ID_W){1'b0}}, first_module_i};
      end
      OP_POLL: begin
        if (in_range) begin
          if (!queried_q[idx]) begin
            queried_d[idx] = 1'b1;
            send           = 1'b1;
          end else if (wait_inc > {1'b0, retry_limit_i}) begin
            wait_d = '0;
            send   = 1'b1;
          end else begin
            wait_d = wait_inc[WAIT_W-1:0];
          end
        end
      end
      OP_REPLY: begin
        if (in_range &&
            reply_module_i == {{(REPLY_W-ACTIVE_W){1'b0}}, active_q}) begin
          answered_d[idx] = 1'b1;
          active_d        = active_q + {{(ACTIVE_W-1){1'b0}}, 1'b1};
        end
      end
      default: ;
    endcase
  end

  // All modules from the first id onward answered, on the updated flags
  always_comb begin
    done = 1'b1;
    for (int i = 0; i < MODULE_COUNT; i++) begin
      if (ID_W'(i) >= first_module_i && !answered_d[i]) begin
        done = 1'b0;
      end
    end
  end

  always_comb begin
    result_o.send_query     = send;
    result_o.query_target   = send ? TARGET_W'(idx) : '0;
    result_o.current_module = active_d;
    result_o.all_done       = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queried_q  <= '0;
      answered_q <= '0;
      wait_q     <= '0;
      active_q   <= {{(ACTIVE_W-ID_W){1'b0}}, FIRST_RESET};
    end else if (step_i) begin
      queried_q  <= queried_d;
      answered_q <= answered_d;
      wait_q     <= wait_d;
      active_q   <= active_d;
    end
  end

endmodule
